// ===== hw/rtl/memop_pkg.sv =====
// Shared types and constants for the memory operation counter.
// Used by memop_ctrl, memop_dp and memop_load_store_counter_core; no dependencies.
package memop_pkg;

   localparam int COUNT_W = 30;
   localparam int LEN_W   = 32;

   localparam logic MODE_COPY = 1'b0;
   localparam logic MODE_FILL = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [5:0]        dst_addr_low;
      logic [2:0]        src_addr_low;
      logic [7:0]        fill_byte;
      logic [LEN_W-1:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] load_count;
      logic [COUNT_W-1:0] store_count;
      logic               store_overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic copy_head;
      logic copy_tail;
      logic fill_step;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_done;
   } dp_status_type;

   // Naturally aligned 1, 2 and 4 byte stores needed for a tail of 0 to 7 bytes.
   function automatic logic [1:0] tail_pieces(input logic [2:0] bytes);
      logic [1:0] pieces;
      begin
         pieces = {1'b0, bytes[0]} + {1'b0, bytes[1]} + {1'b0, bytes[2]};
         return pieces;
      end
   endfunction

   // Saturating subtract on small byte counts.
   function automatic logic [3:0] sat_sub(input logic [3:0] value, input logic [3:0] room);
      logic [3:0] diff;
      begin
         diff = (value > room) ? (value - room) : 4'd0;
         return diff;
      end
   endfunction

endpackage

// ===== hw/rtl/memop_dp.sv =====
// Datapath of the memory operation counter: request registers, copy arithmetic
// and the fill alignment step. Depends on memop_pkg; driven by memop_ctrl.
module memop_dp #(
   parameter int MAX_FILL_STORES = 65580
) (
   input  logic                      clock,
   input  memop_pkg::req_type        req_data,
   input  memop_pkg::dp_cmd_type     cmd,
   output memop_pkg::dp_status_type  status,
   output memop_pkg::rsp_type        result
);
   import memop_pkg::*;

   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(MAX_FILL_STORES);

   logic [5:0]         dst_ff, dst_in;
   logic [2:0]         src_ff;
   logic               zero_fill_ff;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [COUNT_W-1:0] ld_ff, ld_in;
   logic [COUNT_W-1:0] st_ff, st_in;
   logic [3:0]         pend_ff, pend_in;
   logic               over_ff, over_in;

   // Copy head terms.
   logic [3:0]       src_room, dst_room, head, take, head_take;
   logic [LEN_W-1:0] len_head;
   // Copy tail terms.
   logic [COUNT_W-1:0] beats;
   logic [4:0]         tail_sum;
   logic               tail_full;
   // Fill step terms.
   logic [COUNT_W-1:0] pieces, fill_total;

   always_comb begin
      src_room  = 4'd8 - {1'b0, src_ff};
      dst_room  = 4'd8 - {1'b0, dst_ff[2:0]};
      head      = (len_ff < {28'd0, src_room}) ? len_ff[3:0] : src_room;
      len_head  = len_ff - {28'd0, head};
      take      = (len_head < 32'd8) ? len_head[3:0] : 4'd8;
      head_take = head + take;
      beats     = {1'b0, len_ff[LEN_W-1:3]};
      tail_sum  = {1'b0, pend_ff} + {2'b00, len_ff[2:0]};
      tail_full = tail_sum[4] | tail_sum[3];
   end

   always_comb begin
      dst_in  = dst_ff;
      len_in  = len_ff;
      ld_in   = ld_ff;
      st_in   = st_ff;
      pend_in = pend_ff;
      over_in = over_ff;
      pieces  = '0;
      fill_total = '0;

      if (cmd.load) begin
         dst_in  = req_data.dst_addr_low;
         len_in  = req_data.byte_count;
         ld_in   = '0;
         st_in   = '0;
         pend_in = '0;
         over_in = 1'b0;
      end else if (cmd.copy_head) begin
         if (len_ff != '0) begin
            if (src_ff == dst_ff[2:0]) begin
               if (dst_ff[2:0] != 3'd0) begin
                  ld_in  = COUNT_W'(2);
                  st_in  = COUNT_W'(1);
                  len_in = len_head;
               end
            end else if (src_ff > dst_ff[2:0]) begin
               if (dst_ff[2:0] != 3'd0) begin
                  // Two head loads, plus a third when more data follows the first word.
                  ld_in   = (len_head != '0) ? COUNT_W'(3) : COUNT_W'(2);
                  st_in   = COUNT_W'(1);
                  len_in  = len_head - {28'd0, take};
                  pend_in = sat_sub(head_take, dst_room);
               end else begin
                  ld_in   = COUNT_W'(1);
                  len_in  = len_head;
                  pend_in = head;
               end
            end else begin
               ld_in   = COUNT_W'(2);
               st_in   = COUNT_W'(1);
               len_in  = len_head;
               pend_in = sat_sub(head, dst_room);
            end
         end
      end else if (cmd.copy_tail) begin
         ld_in = ld_ff + beats + COUNT_W'(len_ff[2:0] != 3'd0);
         // Bytes past a full word wrap into the low three bits of the sum.
         st_in = st_ff + beats + COUNT_W'(tail_full)
               + COUNT_W'(tail_pieces(tail_sum[2:0]));
      end else if (cmd.fill_step) begin
         if (zero_fill_ff && dst_ff == 6'd0 && len_ff >= 32'd64) begin
            // Aligned zero fill: every remaining whole 64-byte block at once.
            pieces = COUNT_W'(len_ff[LEN_W-1:6]);
            len_in = {26'd0, len_ff[5:0]};
         end else if (dst_ff[2:0] == 3'd0 && len_ff >= 32'd8) begin
            if (!zero_fill_ff) begin
               pieces = beats;
               len_in = {29'd0, len_ff[2:0]};
               dst_in = dst_ff + {beats[2:0], 3'b000};
            end else begin
               pieces = COUNT_W'(1);
               len_in = len_ff - 32'd8;
               dst_in = dst_ff + 6'd8;
            end
         end else if (dst_ff[1:0] == 2'd0 && len_ff >= 32'd4) begin
            pieces = COUNT_W'(1);
            len_in = len_ff - 32'd4;
            dst_in = dst_ff + 6'd4;
         end else if (dst_ff[0] == 1'b0 && len_ff >= 32'd2) begin
            pieces = COUNT_W'(1);
            len_in = len_ff - 32'd2;
            dst_in = dst_ff + 6'd2;
         end else begin
            pieces = COUNT_W'(1);
            len_in = len_ff - 32'd1;
            dst_in = dst_ff + 6'd1;
         end
         fill_total = st_ff + pieces;
         if (fill_total >= CAP) begin
            st_in   = CAP;
            over_in = 1'b1;
         end else begin
            st_in = fill_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff       <= req_data.src_addr_low;
         zero_fill_ff <= (req_data.fill_byte == 8'd0);
      end
      dst_ff  <= dst_in;
      len_ff  <= len_in;
      ld_ff   <= ld_in;
      st_ff   <= st_in;
      pend_ff <= pend_in;
      over_ff <= over_in;
   end

   assign status.fill_done      = (len_ff == '0) || over_ff;
   assign result.load_count     = ld_ff;
   assign result.store_count    = st_ff;
   assign result.store_overflow = over_ff;

endmodule

// ===== hw/rtl/memop_ctrl.sv =====
// Controller of the memory operation counter: sequences copy and fill work.
// Depends on memop_pkg; commands memop_dp.
module memop_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_mode,
   input  memop_pkg::dp_status_type  status,
   output memop_pkg::dp_cmd_type     cmd,
   output logic                      busy,
   output logic                      rsp_valid
);
   import memop_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_COPY_HEAD = 3'd1;
   localparam logic [2:0] ST_COPY_TAIL = 3'd2;
   localparam logic [2:0] ST_FILL      = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_mode == MODE_FILL) ? ST_FILL : ST_COPY_HEAD;
            end
         end
         ST_COPY_HEAD: begin
            cmd.copy_head = 1'b1;
            state_in      = ST_COPY_TAIL;
         end
         ST_COPY_TAIL: begin
            cmd.copy_tail = 1'b1;
            state_in      = ST_DONE;
         end
         ST_FILL: begin
            if (status.fill_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   // Only one datapath operation may run in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.copy_head, cmd.copy_tail, cmd.fill_step}))
      else $error("memop_ctrl: more than one datapath command");

   // A copy always runs its head step right after the request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_COPY) |=> cmd.copy_head)
      else $error("memop_ctrl: copy did not start with the head step");

   // Fill steps stop once the datapath reports the walk is finished.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && status.fill_done) |=> rsp_valid)
      else $error("memop_ctrl: finished fill did not report");

endmodule

// ===== hw/rtl/memop_load_store_counter_core.sv =====
// Top level of the memory operation counter for block copy and fill.
// Depends on memop_pkg and instantiates memop_ctrl and memop_dp.
//
// Usage:
//   A request word is taken at a rising edge where start is high and busy is
//   low. Each request yields one response word on rsp_data, shown for exactly
//   one cycle while rsp_valid is high; busy stays high until after that cycle.
//   Copy mode (mode 0) passes from acceptance through the head alignment
//   step, the beat and tail count step and the response before busy falls.
//   Fill mode (mode 1) runs N fill steps, then a step that sees the walk
//   finished and then the response. A step covers one aligned piece, all
//   whole 8-byte blocks of a nonzero fill or all whole 64-byte blocks of a
//   zero fill, so N is at most 21, bounded by the alignment walk in the
//   datapath. A zero-length fill runs no fill step. The next request can be
//   taken at an edge after busy falls. One request is worked on at a time.
//   Synchronous reset returns the controller to idle; no response is pending
//   afterwards. The receiver cannot stall the response.
module memop_load_store_counter_core #(
   parameter int MAX_FILL_STORES = 65580
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  memop_pkg::req_type  req_data,
   output logic                rsp_valid,
   output memop_pkg::rsp_type  rsp_data
);
   import memop_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   memop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_data.mode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   memop_dp #(
      .MAX_FILL_STORES (MAX_FILL_STORES)
   ) u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .result   (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("core: response strobe held longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("core: response shown while idle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.store_overflow) |->
         (rsp_data.store_count == COUNT_W'(MAX_FILL_STORES) && rsp_data.load_count == '0))
      else $error("core: overflow without store count at the cap");

endmodule

// ===== verif/memop_load_store_counter_core_tb.sv =====
// Self-checking testbench for memop_load_store_counter_core (copy and fill op counts).
// Depends on memop_pkg and the core RTL.
// Predicts each response word and compares it field by field.
module memop_load_store_counter_core_tb;
   import memop_pkg::*;

   localparam int MAX_FILL_STORES = 65580;
   localparam int RANDOM_ITEMS    = 1030;
   localparam int MAX_REPORTS     = 10;

   // Holds the predicted op counts for accepted request words, oldest first.
   class memop_count_board;
      rsp_type count_q[$];
      int      errors;

      function longint unsigned min64(input longint unsigned a, input longint unsigned b);
         return (a < b) ? a : b;
      endfunction

      function void copy_ops(input logic [2:0] dst, input logic [2:0] src,
                             input longint unsigned len_in,
                             output longint unsigned loads, output longint unsigned stores);
         longint unsigned ld, st, pend, rem, len, take, d, s;
         ld = 0;
         st = 0;
         pend = 0;
         len = len_in;
         d = dst;
         s = src;
         loads = 0;
         stores = 0;
         if (len == 0) return;
         if (s == d) begin
            if (d != 0) begin
               ld += 2;
               len -= min64(8 - s, len);
               st++;
            end
         end else if (s > d) begin
            if (d != 0) begin
               ld += 2;
               pend = min64(8 - s, len);
               len -= pend;
               if (len > 0) begin
                  take = min64(8, len);
                  ld += 1;
                  pend += take;
                  len -= take;
               end
               st++;
               pend -= min64(8 - d, pend);
            end else begin
               ld += 1;
               pend = min64(8 - s, len);
               len -= pend;
            end
         end else begin
            ld += 2;
            pend = min64(8 - s, len);
            len -= pend;
            st++;
            pend -= min64(8 - d, pend);
         end
         ld += len / 8;
         st += len / 8;
         rem = len % 8;
         pend += rem;
         if (rem > 0) ld++;
         if (pend >= 8) begin
            st++;
            pend -= 8;
         end
         // A tail of up to seven bytes takes one aligned store per set bit.
         if (pend < 8) st += $countones(pend[2:0]);
         loads = ld;
         stores = st;
      endfunction

      // Greedy aligned walk over the destination; stops at the store cap.
      function longint unsigned fill_stores(input logic [5:0] dst, input logic [7:0] fill,
                                            input longint unsigned len_in, output bit over);
         longint unsigned n, len, step;
         logic [5:0] addr;
         bit zero_fill;
         n = 0;
         len = len_in;
         addr = dst;
         zero_fill = (fill == 8'h00);
         over = 1'b0;
         while (len > 0) begin
            if (zero_fill && addr == 6'd0 && len >= 64) step = 64;
            else if (addr[2:0] == 3'd0 && len >= 8) step = 8;
            else if (addr[1:0] == 2'd0 && len >= 4) step = 4;
            else if (addr[0] == 1'b0 && len >= 2) step = 2;
            else step = 1;
            n++;
            len -= step;
            addr = addr + step[5:0];
            if (n >= MAX_FILL_STORES) begin
               over = 1'b1;
               break;
            end
         end
         return n;
      endfunction

      function void note_request(input req_type r);
         longint unsigned loads, stores;
         bit over;
         rsp_type counts;
         loads = 0;
         stores = 0;
         over = 1'b0;
         if (r.mode == MODE_COPY)
            copy_ops(r.dst_addr_low[2:0], r.src_addr_low, r.byte_count, loads, stores);
         else
            stores = fill_stores(r.dst_addr_low, r.fill_byte, r.byte_count, over);
         counts.load_count = loads[COUNT_W-1:0];
         counts.store_count = stores[COUNT_W-1:0];
         counts.store_overflow = over;
         count_q.insert(count_q.size(), counts);
      endfunction

      function void report(input string field, input longint unsigned want,
                           input longint unsigned got);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("result error: %s expected %0d, got %0d", field, want, got);
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (count_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("result error: unexpected response word %p", got);
            return;
         end
         want = count_q[0];
         count_q.delete(0);
         if (got.load_count !== want.load_count)
            report("load_count", want.load_count, got.load_count);
         if (got.store_count !== want.store_count)
            report("store_count", want.store_count, got.store_count);
         if (got.store_overflow !== want.store_overflow)
            report("store_overflow", want.store_overflow, got.store_overflow);
      endfunction

      function int pending();
         return count_q.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   memop_count_board board;

   memop_load_store_counter_core #(
      .MAX_FILL_STORES(MAX_FILL_STORES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial board = new;

   // Request words are noted and responses checked on the values sampled at the edge.
   always @(posedge clock) begin
      if (!reset && start === 1'b1 && busy === 1'b0) board.note_request(req_data);
      if (!reset && rsp_valid === 1'b1) board.check_response(rsp_data);
   end

   function automatic req_type make_req(input logic mode, input logic [5:0] dst,
                                        input logic [2:0] src, input logic [7:0] fill,
                                        input logic [31:0] len);
      req_type r;
      r.mode = mode;
      r.dst_addr_low = dst;
      r.src_addr_low = src;
      r.fill_byte = fill;
      r.byte_count = len;
      return r;
   endfunction

   function automatic logic [31:0] random_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return $urandom_range(40);
      else if (pick < 65) return $urandom_range(300);
      else if (pick < 77) return $urandom_range(5000);
      else if (pick < 87) return $urandom;
      else if (pick < 93) return 64 * MAX_FILL_STORES - 100 + $urandom_range(200);
      else return 8 * MAX_FILL_STORES - 40 + $urandom_range(80);
   endfunction

   function automatic req_type random_req();
      logic [7:0] fill;
      fill = ($urandom_range(99) < 35) ? 8'h00 : 8'($urandom);
      return make_req(1'($urandom), 6'($urandom), 3'($urandom), fill, random_length());
   endfunction

   task automatic send_word(input req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // The first edge lets the monitor note a word accepted at the previous edge.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic maybe_idle(input bit quiet);
      if (!quiet && $urandom_range(99) < 35) begin
         if ($urandom_range(9) == 0) idle_for($urandom_range(8, 30));
         else idle_for($urandom_range(1, 4));
      end
   endtask

   initial begin
      req_type directed_q[$];
      bit quiet;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero length, unused fields set, every head alignment case, extreme lengths and the fill cap.
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h3f, 3'd7, 8'hff, 32'd0));
      directed_q.insert(directed_q.size(), make_req(MODE_FILL, 6'h3f, 3'd7, 8'hff, 32'd0));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h00, 3'd0, 8'h00, 32'd1));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h38, 3'd0, 8'hff, 32'd64));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h05, 3'd5, 8'h00, 32'd3));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h03, 3'd3, 8'h00, 32'd29));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h02, 3'd6, 8'h00, 32'd1));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h01, 3'd7, 8'h00, 32'd23));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h00, 3'd4, 8'h00, 32'd2));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h00, 3'd3, 8'h00, 32'd37));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h07, 3'd1, 8'h00, 32'd5));
      directed_q.insert(directed_q.size(), make_req(MODE_COPY, 6'h06, 3'd2, 8'h00, 32'd31));
      directed_q.insert(directed_q.size(),
                        make_req(MODE_COPY, 6'h07, 3'd0, 8'hff, 32'hffff_ffff));
      directed_q.insert(directed_q.size(),
                        make_req(MODE_COPY, 6'h01, 3'd6, 8'h00, 32'hffff_ffff));
      directed_q.insert(directed_q.size(), make_req(MODE_FILL, 6'h00, 3'd7, 8'h00, 32'd64));
      directed_q.insert(directed_q.size(), make_req(MODE_FILL, 6'h01, 3'd0, 8'h00, 32'd200));
      directed_q.insert(directed_q.size(), make_req(MODE_FILL, 6'h3f, 3'd0, 8'hff, 32'd7));
      directed_q.insert(directed_q.size(), make_req(MODE_FILL, 6'h2a, 3'd0, 8'h01, 32'd77));
      directed_q.insert(directed_q.size(),
                        make_req(MODE_FILL, 6'h00, 3'd0, 8'h00, 32'd4197120));
      directed_q.insert(directed_q.size(),
                        make_req(MODE_FILL, 6'h00, 3'd0, 8'h00, 32'd4197119));
      directed_q.insert(directed_q.size(),
                        make_req(MODE_FILL, 6'h00, 3'd0, 8'h80, 32'd524640));
      directed_q.insert(directed_q.size(),
                        make_req(MODE_FILL, 6'h00, 3'd0, 8'h80, 32'd524639));
      directed_q.insert(directed_q.size(),
                        make_req(MODE_FILL, 6'h01, 3'd7, 8'hff, 32'hffff_ffff));
      directed_q.insert(directed_q.size(),
                        make_req(MODE_FILL, 6'h00, 3'd0, 8'h00, 32'hffff_ffff));

      foreach (directed_q[i]) begin
         maybe_idle(1'b0);
         send_word(directed_q[i]);
      end
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= 300 && i < 520);
         if (i == 700) drain();
         else maybe_idle(quiet);
         send_word(random_req());
      end

      drain();
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
